// ----- design/kvt_pkg.sv -----
// kvt_pkg: types and constants shared by the keyed value table files.
// Request and status codes, sequencer states, store control struct.
// No dependencies.
package kvt_pkg;

   localparam int KEY_W           = 64;
   localparam int VAL_W           = 64;
   localparam int ENTRIES_DEFAULT = 16;

   // request codes as carried on the request channel
   typedef enum logic [1:0] {
      REQ_DECLARE = 2'd0,
      REQ_READ    = 2'd1,
      REQ_WRITE   = 2'd2,
      REQ_ASK     = 2'd3
   } req_code_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DECLARED  = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_COMMIT
   } state_type;

   // control from the sequencer to the entry store
   typedef struct packed {
      logic key_we;
      logic val_we;
      logic rd_en;
   } store_ctl_type;

endpackage

// ----- design/kvt_if.sv -----
// kvt_if: valid/ready channel interfaces for requests and responses.
// Depends on kvt_pkg for payload widths.
interface kvt_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                req_type;
   logic [kvt_pkg::KEY_W-1:0] key;
   logic [kvt_pkg::VAL_W-1:0] new_value;

   modport source (output valid, req_type, key, new_value, input ready);
   modport sink   (input valid, req_type, key, new_value, output ready);
endinterface

interface kvt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                status;
   logic                      found;
   logic [kvt_pkg::VAL_W-1:0] read_value;

   modport source (output valid, status, found, read_value, input ready);
   modport sink   (input valid, status, found, read_value, output ready);
endinterface

// ----- design/kvt_store.sv -----
// kvt_store: key and value memories, one write port, one registered read port.
// Depends on kvt_pkg.
module kvt_store #(
   parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT,
   parameter int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic                      clock,
   input  kvt_pkg::store_ctl_type    ctl,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [kvt_pkg::KEY_W-1:0] wr_key,
   input  logic [kvt_pkg::VAL_W-1:0] wr_val,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [kvt_pkg::KEY_W-1:0] rd_key,
   output logic [kvt_pkg::VAL_W-1:0] rd_val
);

   logic [kvt_pkg::KEY_W-1:0] key_mem [ENTRIES];
   logic [kvt_pkg::VAL_W-1:0] val_mem [ENTRIES];

   // write port
   always_ff @(posedge clock) begin
      if (ctl.key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (ctl.val_we) begin
         val_mem[wr_addr] <= wr_val;
      end
   end

   // registered read port, key and value at the same address
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_key <= key_mem[rd_addr];
         rd_val <= val_mem[rd_addr];
      end
   end

endmodule

// ----- design/keyed_value_table.sv -----
// keyed_value_table: top level of the linearly searched key/value table.
// Depends on kvt_pkg, kvt_if (kvt_req_if, kvt_rsp_if) and kvt_store.
//
// Usage
//   req (sink): req_type (declare, read, write, ask), key, new_value.
//   rsp (source): status, found, read_value. One response per request,
//   in request order. A transfer happens when valid and ready are high.
//   A request is taken only while the sequencer is idle; it then walks the
//   occupied entries in declaration order through one 64-bit comparator,
//   one entry per cycle, behind the registered read port of the store.
// Sequence
//   A key hit ends the search at the matching entry; a miss ends it once
//   all used entries have been compared. The commit state follows, where
//   the store is updated and the response register loaded once it is free;
//   the response shows on the next cycle and req.ready comes back in that
//   same cycle.
// Reset
//   Synchronous: the table is emptied (entry count zero), no response valid.
// Back-pressure
//   A waiting response does not block the next request's search; the next
//   commit waits until the response register has been emptied.
module keyed_value_table #(
   parameter int ENTRIES = kvt_pkg::ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   kvt_req_if.sink          req,
   kvt_rsp_if.source        rsp
);

   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // control state
   kvt_pkg::state_type        state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic                      pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload state
   kvt_pkg::req_code_type     req_type_ff, req_type_in;
   logic [kvt_pkg::KEY_W-1:0] key_ff, key_in;
   logic [kvt_pkg::VAL_W-1:0] new_val_ff, new_val_in;
   logic [ADDR_W-1:0]         pidx_ff, pidx_in;
   logic                      hit_ff, hit_in;
   logic [ADDR_W-1:0]         hit_idx_ff, hit_idx_in;
   logic [kvt_pkg::VAL_W-1:0] hit_val_ff, hit_val_in;
   kvt_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [kvt_pkg::VAL_W-1:0] rsp_value_ff, rsp_value_in;

   // store connection
   kvt_pkg::store_ctl_type    store_ctl;
   logic [ADDR_W-1:0]         wr_addr;
   logic [kvt_pkg::KEY_W-1:0] rd_key;
   logic [kvt_pkg::VAL_W-1:0] rd_val;
   logic                      key_match;
   logic                      out_free;

   kvt_store #(
      .ENTRIES (ENTRIES),
      .ADDR_W  (ADDR_W)
   ) u_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .wr_addr (wr_addr),
      .wr_key  (key_ff),
      .wr_val  (new_val_ff),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_key  (rd_key),
      .rd_val  (rd_val)
   );

   // shared comparator on the entry read last cycle
   assign key_match = pend_ff && (rd_key == key_ff);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // sequencer: next state and outputs
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      req_type_in   = req_type_ff;
      key_in        = key_ff;
      new_val_in    = new_val_ff;
      pidx_in       = pidx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_val_in    = hit_val_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      store_ctl     = '0;
      wr_addr       = hit_idx_ff;
      req.ready     = 1'b0;

      // response register drains on transfer
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         kvt_pkg::S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               req_type_in = kvt_pkg::req_code_type'(req.req_type);
               key_in      = req.key;
               new_val_in  = req.new_value;
               idx_in      = '0;
               pend_in     = 1'b0;
               state_in    = kvt_pkg::S_SEARCH;
            end
         end

         kvt_pkg::S_SEARCH: begin
            priority if (key_match) begin
               hit_in     = 1'b1;
               hit_idx_in = pidx_ff;
               hit_val_in = rd_val;
               pend_in    = 1'b0;
               state_in   = kvt_pkg::S_COMMIT;
            end else if (idx_ff == count_ff) begin
               hit_in     = 1'b0;
               hit_val_in = '0;
               pend_in    = 1'b0;
               state_in   = kvt_pkg::S_COMMIT;
            end else begin
               store_ctl.rd_en = 1'b1;
               pend_in         = 1'b1;
               pidx_in         = idx_ff[ADDR_W-1:0];
               idx_in          = idx_ff + CNT_W'(1);
            end
         end

         kvt_pkg::S_COMMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_value_in = '0;
               state_in     = kvt_pkg::S_IDLE;
               unique case (req_type_ff)
                  kvt_pkg::REQ_DECLARE: begin
                     priority if (hit_ff) begin
                        rsp_status_in = kvt_pkg::ST_DECLARED;
                     end else if (count_ff == CNT_W'(ENTRIES)) begin
                        rsp_status_in = kvt_pkg::ST_FULL;
                     end else begin
                        rsp_status_in    = kvt_pkg::ST_OK;
                        wr_addr          = count_ff[ADDR_W-1:0];
                        store_ctl.key_we = 1'b1;
                        store_ctl.val_we = 1'b1;
                        count_in         = count_ff + CNT_W'(1);
                     end
                  end
                  kvt_pkg::REQ_READ: begin
                     if (hit_ff) begin
                        rsp_status_in = kvt_pkg::ST_OK;
                        rsp_value_in  = hit_val_ff;
                     end else begin
                        rsp_status_in = kvt_pkg::ST_NOT_FOUND;
                     end
                  end
                  kvt_pkg::REQ_WRITE: begin
                     if (hit_ff) begin
                        rsp_status_in    = kvt_pkg::ST_OK;
                        store_ctl.val_we = 1'b1;
                     end else begin
                        rsp_status_in = kvt_pkg::ST_NOT_FOUND;
                     end
                  end
                  kvt_pkg::REQ_ASK: begin
                     rsp_status_in = kvt_pkg::ST_OK;
                  end
               endcase
            end
         end

         default: begin
            state_in = kvt_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvt_pkg::S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      key_ff        <= key_in;
      new_val_ff    <= new_val_in;
      pidx_ff       <= pidx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_val_ff    <= hit_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // response channel
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.read_value = rsp_value_ff;

endmodule

// ----- design/kvt_checker.sv -----
// kvt_checker: port-level assertions for keyed_value_table, bound to the top.
// Depends on kvt_pkg.
module kvt_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_status,
   input logic                      rsp_found,
   input logic [kvt_pkg::VAL_W-1:0] rsp_read_value
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found) && $stable(rsp_read_value))
      else $error("response changed while stalled");

   // one request at a time: busy after each request transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a non-zero value only comes from a successful read
   a_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_value != '0) |->
         rsp_found && (rsp_status == kvt_pkg::ST_OK))
      else $error("read value without a hit");

   // status agrees with the found flag
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_found && rsp_status != kvt_pkg::ST_NOT_FOUND
            && rsp_status != kvt_pkg::ST_FULL)
         || (!rsp_found && rsp_status != kvt_pkg::ST_DECLARED))
      else $error("status inconsistent with found flag");

endmodule

bind keyed_value_table kvt_checker u_kvt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_status     (rsp.status),
   .rsp_found      (rsp.found),
   .rsp_read_value (rsp.read_value)
);
